[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion macros, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define APQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define APQ_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define APQ_ASSERT(label, prop, msg)
`define APQ_NEVER(label, cond, msg)
`endif
`endif

[hdl/apq_pkg.sv]
// ----------------------------------------------------------------------------
// apq_pkg
// types, codes and color arithmetic shared by the palette quantizer
// ----------------------------------------------------------------------------
package apq_pkg;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [7:0]  pixel_index;
        logic [1:0]  outcome;
        logic [15:0] entry_color;
    } result_t;

    typedef struct packed {
        logic        is_new;
        logic [7:0]  index;
        logic [15:0] color;
    } job_t;

    typedef struct packed {
        logic        en;
        logic [14:0] key;
        logic [7:0]  index;
    } seen_wr_t;

    localparam logic [1:0] OUT_KNOWN  = 2'd0;
    localparam logic [1:0] OUT_NEW    = 2'd1;
    localparam logic [1:0] OUT_MERGED = 2'd2;
    localparam logic [1:0] OUT_FORCED = 2'd3;

    localparam logic [1:0] CFG_FIRST_INDEX     = 2'd0;
    localparam logic [1:0] CFG_PALETTE_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_MERGE_THRESHOLD = 2'd2;

    localparam int KEY_W      = 15;
    localparam int SEEN_DEPTH = 32768;

    // c * 31 / 255
    function automatic logic [4:0] to5(input logic [7:0] c);
        logic [12:0] n;
        logic [15:0] s;
        n = {5'd0, c} * 13'd31;
        s = {3'd0, n} + {11'd0, n[12:8]} + 16'd1;
        return s[12:8];
    endfunction

    // v * 255 / 31
    function automatic logic [7:0] expand(input logic [4:0] v);
        logic [12:0] n;
        logic [29:0] p;
        n = {8'd0, v} * 13'd255;
        p = {17'd0, n} * 30'd67651;
        return p[28:21];
    endfunction

    function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [9:0] distance(input logic [14:0] a, input logic [14:0] b);
        logic [9:0] d;
        d = {2'd0, absdiff(expand(a[4:0]), expand(b[4:0]))}
          + {2'd0, absdiff(expand(a[9:5]), expand(b[9:5]))}
          + {2'd0, absdiff(expand(a[14:10]), expand(b[14:10]))};
        return d;
    endfunction

endpackage

[hdl/apq_front.sv]
// ----------------------------------------------------------------------------
// apq_front
// pixel intake, rgb555 reduction and seen-color map lookup
// ----------------------------------------------------------------------------
module apq_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  apq_pkg::pixel_t   s_data,
    input  apq_pkg::seen_wr_t seen_wr,
    output logic              q_push,
    output apq_pkg::job_t     q_item,
    input  logic              q_full,
    output logic              clearing
);

    logic [8:0]  seen_mem [apq_pkg::SEEN_DEPTH];
    logic [8:0]  seen_rd_reg;
    logic        clr_reg;
    logic [14:0] clr_cnt_reg;
    logic        pend_reg;
    logic        pend_next;
    logic        hold_vld_reg;
    logic        hold_vld_next;
    logic [15:0] hold_color_reg;
    logic [14:0] in_key;
    logic        rd_en;
    logic        mem_we;
    logic [14:0] mem_wa;
    logic [8:0]  mem_wd;

    assign in_key = {apq_pkg::to5(s_data.blue_in), apq_pkg::to5(s_data.green_in),
                     apq_pkg::to5(s_data.red_in)};

    assign s_ready = !clr_reg && !pend_reg &&
                     (!hold_vld_reg || (!q_full && seen_rd_reg[8]));
    assign rd_en   = s_valid && s_ready;
    assign q_push  = hold_vld_reg && !q_full;
    assign q_item  = '{is_new: !seen_rd_reg[8], index: seen_rd_reg[7:0],
                       color: hold_color_reg};
    assign clearing = clr_reg;

    assign mem_we = clr_reg || seen_wr.en;
    assign mem_wa = clr_reg ? clr_cnt_reg : seen_wr.key;
    assign mem_wd = clr_reg ? 9'd0 : {1'b1, seen_wr.index};

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            seen_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            seen_rd_reg    <= seen_mem[in_key];
            hold_color_reg <= {1'b1, in_key};
        end
    end

    always_comb begin
        hold_vld_next = hold_vld_reg;
        if (q_push) begin
            hold_vld_next = 1'b0;
        end
        if (rd_en) begin
            hold_vld_next = 1'b1;
        end
        pend_next = pend_reg;
        if (seen_wr.en) begin
            pend_next = 1'b0;
        end
        if (q_push && q_item.is_new) begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg      <= 1'b1;
            clr_cnt_reg  <= '0;
            pend_reg     <= 1'b0;
            hold_vld_reg <= 1'b0;
        end else begin
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 15'd1;
                if (&clr_cnt_reg) begin
                    clr_reg <= 1'b0;
                end
            end
            pend_reg     <= pend_next;
            hold_vld_reg <= hold_vld_next;
        end
    end

endmodule

[hdl/apq_queue.sv]
// ----------------------------------------------------------------------------
// apq_queue
// short fifo of classified words between lookup and palette search
// ----------------------------------------------------------------------------
module apq_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  apq_pkg::job_t push_item,
    output logic          full,
    input  logic          pop,
    output apq_pkg::job_t pop_item,
    output logic          empty
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    apq_pkg::job_t    slots_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;

    assign full     = (count_reg == (PW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = slots_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (PW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (PW+1)'(1);
            end
        end
    end

endmodule

[hdl/apq_back.sv]
// ----------------------------------------------------------------------------
// apq_back
// palette search, merge or append decision and result register
// ----------------------------------------------------------------------------
module apq_back #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [7:0]        first_index,
    input  logic [7:0]        palette_limit,
    input  logic [9:0]        merge_threshold,
    input  logic              q_empty,
    input  apq_pkg::job_t     q_item,
    output logic              q_pop,
    output apq_pkg::seen_wr_t seen_wr,
    output logic              m_valid,
    input  logic              m_ready,
    output apq_pkg::result_t  m_data
);

    localparam int AW = $clog2(PALETTE_ENTRIES);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [15:0]      pal_mem [PALETTE_ENTRIES];
    logic [15:0]      pal_rd_reg;
    logic [1:0]       state_reg, state_next;
    logic [15:0]      color_reg, color_next;
    logic [8:0]       used_reg, used_next;
    logic [8:0]       k_reg, k_next;
    logic             rd_vld_reg, rd_vld_next;
    logic             found_reg, found_next;
    logic [9:0]       best_dist_reg, best_dist_next;
    logic [8:0]       best_idx_reg, best_idx_next;
    logic             m_valid_reg, m_valid_next;
    apq_pkg::result_t m_data_reg, m_data_next;

    logic [8:0]       scan_idx;
    logic             can_issue;
    logic [9:0]       cur_dist;
    logic [9:0]       next_idx;
    logic             pal_full;
    logic             out_free;
    logic             pal_we;

    assign scan_idx  = {1'b0, first_index} + k_reg;
    assign can_issue = (state_reg == ST_SCAN) && (k_reg < used_reg) &&
                       ({1'b0, scan_idx} < 10'(PALETTE_ENTRIES));
    assign cur_dist  = apq_pkg::distance(color_reg[14:0], pal_rd_reg[14:0]);
    assign next_idx  = {2'd0, first_index} + {1'b0, used_reg};
    assign pal_full  = (next_idx > {2'd0, palette_limit}) ||
                       (next_idx >= 10'(PALETTE_ENTRIES));
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (pal_we) begin
            pal_mem[next_idx[AW-1:0]] <= color_reg;
        end
        if (can_issue) begin
            pal_rd_reg <= pal_mem[scan_idx[AW-1:0]];
        end
    end

    always_comb begin
        state_next     = state_reg;
        color_next     = color_reg;
        used_next      = used_reg;
        k_next         = k_reg;
        rd_vld_next    = 1'b0;
        found_next     = found_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        q_pop          = 1'b0;
        pal_we         = 1'b0;
        seen_wr        = '{en: 1'b0, key: color_reg[14:0], index: best_idx_reg[7:0]};

        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    if (q_item.is_new) begin
                        q_pop         = 1'b1;
                        color_next    = q_item.color;
                        k_next        = '0;
                        found_next    = 1'b0;
                        best_idx_next = {1'b0, first_index};
                        state_next    = ST_SCAN;
                    end else if (out_free) begin
                        q_pop        = 1'b1;
                        m_valid_next = 1'b1;
                        m_data_next  = '{pixel_index: q_item.index,
                                         outcome: apq_pkg::OUT_KNOWN,
                                         entry_color: 16'd0};
                    end
                end
            end
            ST_SCAN: begin
                if (rd_vld_reg && (!found_reg || cur_dist < best_dist_reg)) begin
                    found_next     = 1'b1;
                    best_dist_next = cur_dist;
                    best_idx_next  = scan_idx - 9'd1;
                end
                if (can_issue) begin
                    rd_vld_next = 1'b1;
                    k_next      = k_reg + 9'd1;
                end else if (!rd_vld_reg) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    seen_wr.en   = 1'b1;
                    if (found_reg && ({1'b0, best_dist_reg} < {1'b0, merge_threshold})) begin
                        m_data_next = '{pixel_index: best_idx_reg[7:0],
                                        outcome: apq_pkg::OUT_MERGED,
                                        entry_color: 16'd0};
                    end else if (pal_full) begin
                        m_data_next = '{pixel_index: best_idx_reg[7:0],
                                        outcome: apq_pkg::OUT_FORCED,
                                        entry_color: 16'd0};
                    end else begin
                        pal_we        = 1'b1;
                        used_next     = used_reg + 9'd1;
                        seen_wr.index = next_idx[7:0];
                        m_data_next   = '{pixel_index: next_idx[7:0],
                                          outcome: apq_pkg::OUT_NEW,
                                          entry_color: color_reg};
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        color_reg     <= color_next;
        k_reg         <= k_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
        m_data_reg    <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            rd_vld_reg  <= 1'b0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            rd_vld_reg  <= rd_vld_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

[hdl/adaptive_palette_quantizer.sv]
// ----------------------------------------------------------------------------
// adaptive_palette_quantizer
// rgb888 pixels to palette indexes with an adaptive rgb555 palette
// ----------------------------------------------------------------------------
// s_ carries one pixel word (valid/ready), m_ carries one result word per
// pixel in the same order: palette index, outcome and the new entry color.
// cfg_we/cfg_addr/cfg_wdata write first_index, palette_limit and
// merge_threshold; write them only while no pixel is in flight.
// after reset the seen-color map is cleared one entry a cycle, all 32768
// entries with s_ready low; configuration writes are taken during that time.
// a known color's result word passes the hold register, the queue and the
// output register; known colors are taken one per cycle while the queue
// has room. a new color scans the n filled palette entries one per cycle
// through the palette memory read port.
// a pixel is accepted while earlier known colors still wait in the queue or
// the output register; after a new color the next pixel waits until its map
// entry is written.
// a stalled receiver holds the output register, then the queue fills and
// s_ready drops.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adaptive_palette_quantizer #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  apq_pkg::pixel_t  s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output apq_pkg::result_t m_data,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_addr,
    input  logic [9:0]       cfg_wdata
);

    logic [7:0]        first_index_reg;
    logic [7:0]        palette_limit_reg;
    logic [9:0]        merge_threshold_reg;
    apq_pkg::seen_wr_t seen_wr;
    apq_pkg::job_t     push_item;
    apq_pkg::job_t     pop_item;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    logic              clearing;
    logic              out_new;
    logic              out_other;

    assign out_new   = m_valid && (m_data.outcome == apq_pkg::OUT_NEW);
    assign out_other = m_valid && (m_data.outcome != apq_pkg::OUT_NEW);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_index_reg     <= 8'd1;
            palette_limit_reg   <= 8'd235;
            merge_threshold_reg <= 10'd5;
        end else if (cfg_we) begin
            case (cfg_addr)
                apq_pkg::CFG_FIRST_INDEX:     first_index_reg     <= cfg_wdata[7:0];
                apq_pkg::CFG_PALETTE_LIMIT:   palette_limit_reg   <= cfg_wdata[7:0];
                apq_pkg::CFG_MERGE_THRESHOLD: merge_threshold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    apq_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .seen_wr  (seen_wr),
        .q_push   (q_push),
        .q_item   (push_item),
        .q_full   (q_full),
        .clearing (clearing)
    );

    apq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    apq_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .first_index     (first_index_reg),
        .palette_limit   (palette_limit_reg),
        .merge_threshold (merge_threshold_reg),
        .q_empty         (q_empty),
        .q_item          (pop_item),
        .q_pop           (q_pop),
        .seen_wr         (seen_wr),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data)
    );

    `APQ_NEVER(a_no_accept_clear, clearing && s_ready, "pixel accepted during map clear")
    `APQ_NEVER(a_no_pop_empty, q_pop && q_empty, "queue popped while empty")
    `APQ_ASSERT(a_new_color_flag, out_new |-> m_data.entry_color[15], "new entry without flag")
    `APQ_ASSERT(a_zero_color, out_other |-> m_data.entry_color == 16'd0, "color on non-new word")

endmodule
